>>> hw/rtl/dtt_pkg.sv
// Shared constants, codes and controller/datapath types for the deadline timer table.
`default_nettype none

package dtt_pkg;

    // Default table size and fixed field widths
    localparam int NUM_SLOTS_DEF = 16;
    localparam int SLOT_W        = 4;
    localparam int TIME_W        = 64;
    localparam int PER_W         = 32;
    localparam int FUNC_W        = 3;
    localparam int STAT_W        = 2;

    localparam logic [PER_W-1:0]  WINDOW_RESET = 32'd3600000;
    localparam logic [TIME_W-1:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

    // Command codes
    localparam logic [FUNC_W-1:0] F_ADD     = 3'd0;
    localparam logic [FUNC_W-1:0] F_CANCEL  = 3'd1;
    localparam logic [FUNC_W-1:0] F_REFRESH = 3'd2;
    localparam logic [FUNC_W-1:0] F_RESET   = 3'd3;
    localparam logic [FUNC_W-1:0] F_NEXT    = 3'd4;
    localparam logic [FUNC_W-1:0] F_EXPIRE  = 3'd5;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_INACT = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_NONE  = 2'd3;

    // Scan modes: earliest active, earliest due, mark due slots
    localparam logic [1:0] SM_ACT  = 2'd0;
    localparam logic [1:0] SM_DUE  = 2'd1;
    localparam logic [1:0] SM_MARK = 2'd2;

    // Result kinds loaded into the result stage
    localparam logic [2:0] RK_PLAIN = 3'd0;
    localparam logic [2:0] RK_ADDW  = 3'd1;
    localparam logic [2:0] RK_RSTW  = 3'd2;
    localparam logic [2:0] RK_WAIT  = 3'd3;
    localparam logic [2:0] RK_FIRE  = 3'd4;

    // Controller to datapath commands
    typedef struct packed {
        logic              latch;
        logic              do_add;
        logic              do_cancel;
        logic              do_refresh;
        logic              rst_base;
        logic              rst_write;
        logic              clr_pend;
        logic              scan_start;
        logic [1:0]        scan_mode;
        logic              exp_prep;
        logic              exp_roll;
        logic              fire;
        logic              res_load;
        logic [2:0]        res_kind;
        logic [STAT_W-1:0] res_status;
        logic              emit;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic              full;
        logic              tgt_valid;
        logic              tgt_active;
        logic              per_same;
        logic              from_now;
        logic              any_active;
        logic              any_due;
        logic              scan_busy;
        logic              out_free;
        logic [FUNC_W-1:0] func;
    } t_dp_st;

endpackage

`default_nettype wire

>>> hw/rtl/dtt_if.sv
// Valid/ready channel interfaces for command words and result words.
`default_nettype none

interface dtt_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [63:0] now_ms;
    logic [3:0]  slot_in;
    logic [31:0] period_ms;
    logic        repeat_req;
    logic        from_now;

    modport source (output valid, func, now_ms, slot_in, period_ms, repeat_req, from_now,
                    input ready);
    modport sink   (input valid, func, now_ms, slot_in, period_ms, repeat_req, from_now,
                    output ready);
endinterface

interface dtt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [3:0]  slot_out;
    logic [63:0] wait_ms;
    logic        fired;
    logic        last;
    logic        front_wake;
    logic        any_armed;

    modport source (output valid, status, slot_out, wait_ms, fired, last, front_wake,
                    any_armed, input ready);
    modport sink   (input valid, status, slot_out, wait_ms, fired, last, front_wake,
                    any_armed, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/deadline_timer_table.sv
// Deadline timer table: top level with config register, controller and datapath.
//
// Usage: command words arrive on i_in (valid/ready), each carrying the current time.
// Every command yields one result word on o_out, except an expire that fires
// slots, which yields one word per fired slot in deadline order, the final one
// flagged by last. The rollover window is written through the APB port at
// addresses 0 to 3 (paddr[2] low), only while the block is idle; the block
// does not enforce this, so the user must keep to it. Reads there return it.
// One word is in work at a time. Cancel, refresh and plain error cases run no
// scan; add, a reset that moves a deadline, and next-wait run one scan over
// the slot memory. Expire runs a marking scan and then one scan per fired
// slot. Scans go through the slot memory's single read port, one slot per
// cycle.
// A registered output stage holds a finished word; a stalled receiver only
// holds back the next result, and a new command is taken once the previous
// command has handed over its last word. Reset clears all slots, the wake
// mark and the previous time, and loads the window default of one hour.
`default_nettype none

module deadline_timer_table #(
    parameter int NUM_SLOTS = dtt_pkg::NUM_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dtt_in_if.sink      i_in,
    dtt_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dtt_pkg::*;

    logic [PER_W-1:0] r_window;
    t_dp_cmd          w_cmd;
    t_dp_st           w_st;
    logic             w_in_ready;

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            r_window <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? r_window : '0;

    dtt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_st       (w_st),
        .o_cmd      (w_cmd)
    );

    assign i_in.ready = w_in_ready;

    dtt_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_st         (w_st),
        .i_window     (r_window),
        .i_func       (i_in.func),
        .i_now_ms     (i_in.now_ms),
        .i_slot_in    (i_in.slot_in),
        .i_period_ms  (i_in.period_ms),
        .i_repeat_req (i_in.repeat_req),
        .i_from_now   (i_in.from_now),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_status     (o_out.status),
        .o_slot_out   (o_out.slot_out),
        .o_wait_ms    (o_out.wait_ms),
        .o_fired      (o_out.fired),
        .o_last       (o_out.last),
        .o_front_wake (o_out.front_wake),
        .o_any_armed  (o_out.any_armed)
    );

    // A result is never loaded over one that the receiver has not taken
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!o_out.valid || o_out.ready))
        else $error("result loaded over a pending word");

    // A scan is never restarted while one is running
    a_scan_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.scan_start |-> !w_st.scan_busy)
        else $error("scan restarted while busy");

    // A fired slot reports success and never a front wake
    a_fire_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.fired) |-> (o_out.status == ST_OK && !o_out.front_wake))
        else $error("fired word with bad status or wake");

    // One command in work at a time
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("second command taken while busy");

endmodule

`default_nettype wire

>>> hw/rtl/dtt_datapath.sv
// Timer table datapath: slot storage, scan unit, deadline arithmetic and result register.
`default_nettype none

module dtt_datapath #(
    parameter int NUM_SLOTS = dtt_pkg::NUM_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dtt_pkg::t_dp_cmd              i_cmd,
    output dtt_pkg::t_dp_st               o_st,
    input  logic [dtt_pkg::PER_W-1:0]     i_window,
    input  logic [dtt_pkg::FUNC_W-1:0]    i_func,
    input  logic [dtt_pkg::TIME_W-1:0]    i_now_ms,
    input  logic [dtt_pkg::SLOT_W-1:0]    i_slot_in,
    input  logic [dtt_pkg::PER_W-1:0]     i_period_ms,
    input  logic                          i_repeat_req,
    input  logic                          i_from_now,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [dtt_pkg::STAT_W-1:0]    o_status,
    output logic [dtt_pkg::SLOT_W-1:0]    o_slot_out,
    output logic [dtt_pkg::TIME_W-1:0]    o_wait_ms,
    output logic                          o_fired,
    output logic                          o_last,
    output logic                          o_front_wake,
    output logic                          o_any_armed
);
    import dtt_pkg::*;

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // Latched command word
    logic [FUNC_W-1:0] r_func;
    logic [TIME_W-1:0] r_now;
    logic              r_slot_valid;
    logic [PER_W-1:0]  r_per_in;
    logic              r_rep_in;
    logic              r_fnow;
    logic [SW-1:0]     r_tgt;

    // Slot flags and misc state
    logic [NUM_SLOTS-1:0] r_active;
    logic [NUM_SLOTS-1:0] r_repeat;
    logic [NUM_SLOTS-1:0] r_due;
    logic                 r_pend;
    logic [TIME_W-1:0]    r_prev;

    // Slot memories, one read and one write port, registered read
    logic [PER_W-1:0]  mem_per [NUM_SLOTS];
    logic [TIME_W-1:0] mem_dl  [NUM_SLOTS];
    logic [PER_W-1:0]  r_rd_per;
    logic [TIME_W-1:0] r_rd_dl;

    // Scan unit
    logic              r_scan_on;
    logic [SW-1:0]     r_scan_cnt;
    logic              r_cmp_v;
    logic [SW-1:0]     r_cmp_idx;
    logic [1:0]        r_mode;
    logic              r_best_v;
    logic [SW-1:0]     r_best_idx;
    logic [TIME_W-1:0] r_best_dl;
    logic [PER_W-1:0]  r_best_per;

    // Arithmetic staging
    logic [TIME_W-1:0] r_base;
    logic [TIME_W-1:0] r_pw_diff;
    logic              r_pw_ge;
    logic              r_roll;

    // Result stage and output register
    logic [STAT_W-1:0] r_res_status;
    logic [SLOT_W-1:0] r_res_slot;
    logic [TIME_W-1:0] r_res_wait;
    logic              r_res_fired;
    logic              r_res_last;
    logic              r_res_wake;
    logic              r_o_valid;
    logic [STAT_W-1:0] r_o_status;
    logic [SLOT_W-1:0] r_o_slot;
    logic [TIME_W-1:0] r_o_wait;
    logic              r_o_fired;
    logic              r_o_last;
    logic              r_o_wake;
    logic              r_o_armed;

    logic [SW-1:0]        w_free;
    logic                 w_full;
    logic [SW-1:0]        w_rd_addr;
    logic [SW-1:0]        w_wr_addr;
    logic                 w_wr_per;
    logic                 w_wr_dl;
    logic [PER_W-1:0]     w_per_val;
    logic [TIME_W-1:0]    w_dl_val;
    logic                 w_cand;
    logic                 w_better;
    logic                 w_wake;
    logic [NUM_SLOTS-1:0] w_best_oh;
    logic [TIME_W-1:0]    w_wait;
    logic                 w_out_free;

    // Lowest free slot
    always_comb begin
        w_free = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                w_free = SW'(i);
            end
        end
    end
    assign w_full = &r_active;

    // Memory port addressing and write data
    assign w_rd_addr = r_scan_on ? r_scan_cnt : r_tgt;
    assign w_wr_addr = i_cmd.do_add ? w_free : (i_cmd.fire ? r_best_idx : r_tgt);
    assign w_wr_per  = i_cmd.do_add | i_cmd.rst_write;
    assign w_per_val = r_per_in;
    assign w_wr_dl   = i_cmd.do_add | i_cmd.do_refresh | i_cmd.rst_write
                     | (i_cmd.fire & r_repeat[r_best_idx]);

    always_comb begin
        if (i_cmd.rst_write) begin
            w_dl_val = r_base + {{(TIME_W-PER_W){1'b0}}, r_per_in};
        end else if (i_cmd.do_refresh) begin
            w_dl_val = r_now + {{(TIME_W-PER_W){1'b0}}, r_rd_per};
        end else if (i_cmd.fire) begin
            w_dl_val = r_now + {{(TIME_W-PER_W){1'b0}}, r_best_per};
        end else begin
            w_dl_val = r_now + {{(TIME_W-PER_W){1'b0}}, r_per_in};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_per) begin
            mem_per[w_wr_addr] <= w_per_val;
        end
        if (w_wr_dl) begin
            mem_dl[w_wr_addr] <= w_dl_val;
        end
        r_rd_per <= mem_per[w_rd_addr];
        r_rd_dl  <= mem_dl[w_rd_addr];
    end

    // Scan compare
    assign w_cand    = (r_mode == SM_ACT) ? r_active[r_cmp_idx] : r_due[r_cmp_idx];
    assign w_better  = !r_best_v || (r_rd_dl < r_best_dl);
    assign w_best_oh = {{(NUM_SLOTS-1){1'b0}}, 1'b1} << r_best_idx;
    assign w_wake    = r_best_v && (r_best_idx == r_tgt) && !r_pend;
    assign w_wait    = !r_best_v ? ALL_ONES
                     : ((r_now >= r_best_dl) ? '0 : r_best_dl - r_now);

    // Scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_on <= 1'b0;
            r_cmp_v   <= 1'b0;
            r_best_v  <= 1'b0;
        end else begin
            r_cmp_v <= r_scan_on;
            if (i_cmd.scan_start) begin
                r_scan_on <= 1'b1;
                r_best_v  <= 1'b0;
            end else if (r_scan_on && r_scan_cnt == SW'(NUM_SLOTS - 1)) begin
                r_scan_on <= 1'b0;
            end
            if (r_cmp_v && r_mode != SM_MARK && w_cand && w_better) begin
                r_best_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_scan_cnt;
        if (i_cmd.scan_start) begin
            r_scan_cnt <= '0;
            r_mode     <= i_cmd.scan_mode;
        end else if (r_scan_on) begin
            r_scan_cnt <= r_scan_cnt + 1'b1;
        end
        if (r_cmp_v && r_mode != SM_MARK && w_cand && w_better) begin
            r_best_idx <= r_cmp_idx;
            r_best_dl  <= r_rd_dl;
            r_best_per <= r_rd_per;
        end
    end

    // Command latch and staging arithmetic
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func       <= i_func;
            r_now        <= i_now_ms;
            r_slot_valid <= ({{(32-SLOT_W){1'b0}}, i_slot_in} < 32'(NUM_SLOTS));
            r_tgt        <= SW'(i_slot_in);
            r_per_in     <= i_period_ms;
            r_rep_in     <= i_repeat_req;
            r_fnow       <= i_from_now;
        end else if (i_cmd.do_add) begin
            r_tgt <= w_free;
        end
        if (i_cmd.rst_base) begin
            r_base <= r_fnow ? r_now : r_rd_dl - {{(TIME_W-PER_W){1'b0}}, r_rd_per};
        end
        if (i_cmd.exp_prep) begin
            r_pw_ge   <= r_prev >= {{(TIME_W-PER_W){1'b0}}, i_window};
            r_pw_diff <= r_prev - {{(TIME_W-PER_W){1'b0}}, i_window};
        end
        if (i_cmd.exp_roll) begin
            r_roll <= r_pw_ge && (r_now < r_pw_diff);
        end
    end

    // Slot flags, wake mark and previous time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_repeat <= '0;
            r_due    <= '0;
            r_pend   <= 1'b0;
            r_prev   <= '0;
        end else begin
            if (i_cmd.latch) begin
                r_due <= '0;
            end
            if (i_cmd.do_add) begin
                r_active[w_free] <= 1'b1;
                r_repeat[w_free] <= r_rep_in;
            end
            if (i_cmd.do_cancel) begin
                r_active[r_tgt] <= 1'b0;
            end
            if (r_cmp_v && r_mode == SM_MARK) begin
                r_due[r_cmp_idx] <= r_active[r_cmp_idx] & (r_roll | (r_rd_dl <= r_now));
            end
            if (i_cmd.fire) begin
                r_due[r_best_idx] <= 1'b0;
                if (!r_repeat[r_best_idx]) begin
                    r_active[r_best_idx] <= 1'b0;
                end
            end
            if (i_cmd.clr_pend) begin
                r_pend <= 1'b0;
            end else if (i_cmd.res_load && w_wake
                         && (i_cmd.res_kind == RK_ADDW || i_cmd.res_kind == RK_RSTW)) begin
                r_pend <= 1'b1;
            end
            if (i_cmd.exp_roll) begin
                r_prev <= r_now;
            end
        end
    end

    // Result stage
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res_status <= ST_OK;
            r_res_slot   <= '0;
            r_res_wait   <= '0;
            r_res_fired  <= 1'b0;
            r_res_last   <= 1'b1;
            r_res_wake   <= 1'b0;
            case (i_cmd.res_kind)
                RK_ADDW: begin
                    r_res_slot <= SLOT_W'(r_tgt);
                    r_res_wake <= w_wake;
                end
                RK_RSTW: begin
                    r_res_wake <= w_wake;
                end
                RK_WAIT: begin
                    r_res_wait <= w_wait;
                end
                RK_FIRE: begin
                    r_res_slot  <= SLOT_W'(r_best_idx);
                    r_res_fired <= 1'b1;
                    r_res_last  <= ~|(r_due & ~w_best_oh);
                end
                default: begin
                    r_res_status <= i_cmd.res_status;
                end
            endcase
        end
    end

    // Output register
    assign w_out_free = !r_o_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_status <= r_res_status;
            r_o_slot   <= r_res_slot;
            r_o_wait   <= r_res_wait;
            r_o_fired  <= r_res_fired;
            r_o_last   <= r_res_last;
            r_o_wake   <= r_res_wake;
            r_o_armed  <= |(r_active & ~(r_due & ~r_repeat));
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_status     = r_o_status;
    assign o_slot_out   = r_o_slot;
    assign o_wait_ms    = r_o_wait;
    assign o_fired      = r_o_fired;
    assign o_last       = r_o_last;
    assign o_front_wake = r_o_wake;
    assign o_any_armed  = r_o_armed;

    // Status to controller
    always_comb begin
        o_st            = '0;
        o_st.full       = w_full;
        o_st.tgt_valid  = r_slot_valid;
        o_st.tgt_active = r_slot_valid & r_active[r_tgt];
        o_st.per_same   = (r_rd_per == r_per_in);
        o_st.from_now   = r_fnow;
        o_st.any_active = |r_active;
        o_st.any_due    = |r_due;
        o_st.scan_busy  = r_scan_on | r_cmp_v;
        o_st.out_free   = w_out_free;
        o_st.func       = r_func;
    end

endmodule

`default_nettype wire

>>> hw/rtl/dtt_ctrl.sv
// Timer table controller: sequences each command word through the datapath.
`default_nettype none

module dtt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  dtt_pkg::t_dp_st  i_st,
    output dtt_pkg::t_dp_cmd o_cmd
);
    import dtt_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_REF1  = 4'd2;
    localparam logic [3:0] S_RST1  = 4'd3;
    localparam logic [3:0] S_RST2  = 4'd4;
    localparam logic [3:0] S_WSCAN = 4'd5;
    localparam logic [3:0] S_WAKE  = 4'd6;
    localparam logic [3:0] S_NSCAN = 4'd7;
    localparam logic [3:0] S_NW    = 4'd8;
    localparam logic [3:0] S_EXP1  = 4'd9;
    localparam logic [3:0] S_MSCAN = 4'd10;
    localparam logic [3:0] S_EXP2  = 4'd11;
    localparam logic [3:0] S_FSCAN = 4'd12;
    localparam logic [3:0] S_FIRE  = 4'd13;
    localparam logic [3:0] S_EMIT  = 4'd14;
    localparam logic [3:0] S_EMITF = 4'd15;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DEC;
                end
            end
            S_DEC: begin
                case (i_st.func)
                    F_ADD: begin
                        if (i_st.full) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_FULL;
                            n_state          = S_EMIT;
                        end else begin
                            o_cmd.do_add     = 1'b1;
                            o_cmd.scan_start = 1'b1;
                            o_cmd.scan_mode  = SM_ACT;
                            n_state          = S_WSCAN;
                        end
                    end
                    F_CANCEL: begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.do_cancel  = i_st.tgt_active;
                        o_cmd.res_status = i_st.tgt_active ? ST_OK : ST_INACT;
                        n_state          = S_EMIT;
                    end
                    F_REFRESH: begin
                        if (i_st.tgt_active) begin
                            n_state = S_REF1;
                        end else begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_INACT;
                            n_state          = S_EMIT;
                        end
                    end
                    F_RESET: begin
                        if (i_st.tgt_valid) begin
                            n_state = S_RST1;
                        end else begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_INACT;
                            n_state          = S_EMIT;
                        end
                    end
                    F_NEXT: begin
                        o_cmd.clr_pend   = 1'b1;
                        o_cmd.scan_start = 1'b1;
                        o_cmd.scan_mode  = SM_ACT;
                        n_state          = S_NSCAN;
                    end
                    F_EXPIRE: begin
                        if (i_st.any_active) begin
                            o_cmd.exp_prep = 1'b1;
                            n_state        = S_EXP1;
                        end else begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_NONE;
                            n_state          = S_EMIT;
                        end
                    end
                    default: begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = ST_OK;
                        n_state          = S_EMIT;
                    end
                endcase
            end
            S_REF1: begin
                o_cmd.do_refresh = 1'b1;
                o_cmd.res_load   = 1'b1;
                o_cmd.res_status = ST_OK;
                n_state          = S_EMIT;
            end
            S_RST1: begin
                if (i_st.per_same && !i_st.from_now) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_OK;
                    n_state          = S_EMIT;
                end else if (!i_st.tgt_active) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_INACT;
                    n_state          = S_EMIT;
                end else begin
                    o_cmd.rst_base = 1'b1;
                    n_state        = S_RST2;
                end
            end
            S_RST2: begin
                o_cmd.rst_write  = 1'b1;
                o_cmd.scan_start = 1'b1;
                o_cmd.scan_mode  = SM_ACT;
                n_state          = S_WSCAN;
            end
            S_WSCAN: begin
                if (!i_st.scan_busy) begin
                    n_state = S_WAKE;
                end
            end
            S_WAKE: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_kind = (i_st.func == F_ADD) ? RK_ADDW : RK_RSTW;
                n_state        = S_EMIT;
            end
            S_NSCAN: begin
                if (!i_st.scan_busy) begin
                    n_state = S_NW;
                end
            end
            S_NW: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_kind = RK_WAIT;
                n_state        = S_EMIT;
            end
            S_EXP1: begin
                o_cmd.exp_roll   = 1'b1;
                o_cmd.scan_start = 1'b1;
                o_cmd.scan_mode  = SM_MARK;
                n_state          = S_MSCAN;
            end
            S_MSCAN: begin
                if (!i_st.scan_busy) begin
                    n_state = S_EXP2;
                end
            end
            S_EXP2: begin
                if (i_st.any_due) begin
                    o_cmd.scan_start = 1'b1;
                    o_cmd.scan_mode  = SM_DUE;
                    n_state          = S_FSCAN;
                end else begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_NONE;
                    n_state          = S_EMIT;
                end
            end
            S_FSCAN: begin
                if (!i_st.scan_busy) begin
                    n_state = S_FIRE;
                end
            end
            S_FIRE: begin
                o_cmd.fire     = 1'b1;
                o_cmd.res_load = 1'b1;
                o_cmd.res_kind = RK_FIRE;
                n_state        = S_EMITF;
            end
            S_EMIT: begin
                if (i_st.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_EMITF: begin
                if (i_st.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_st.any_due) begin
                        o_cmd.scan_start = 1'b1;
                        o_cmd.scan_mode  = SM_DUE;
                        n_state          = S_FSCAN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> tb/deadline_timer_table_test.sv
// Testbench for deadline_timer_table: directed table plus random commands, scoreboarded.
`timescale 1ns / 1ps

module deadline_timer_table_test;
    import dtt_pkg::*;

    localparam int NSLOT = NUM_SLOTS_DEF;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE = 400;
    // codes the block ignores
    localparam logic [FUNC_W-1:0] F_UNUSED6 = 3'd6;
    localparam logic [FUNC_W-1:0] F_UNUSED7 = 3'd7;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [63:0]       now;
        logic [3:0]        slot;
        logic [31:0]       period;
        logic              rep;
        logic              fnow;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot;
        logic [63:0] wait_ms;
        logic        fired;
        logic        last;
        logic        wake;
        logic        armed;
    } timer_word_t;

    // directed row: a command (repeated count times) or a window write
    typedef struct packed {
        logic        is_cfg;
        cmd_t        cmd;
        logic [31:0] count;
        logic        typed;
        logic [1:0]  t_status;
        logic [63:0] t_wait;
    } row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    dtt_in_if  in_ch();
    dtt_out_if out_ch();

    deadline_timer_table dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #2 i_clk = ~i_clk;

    // model copy of the slot table
    logic        m_active [NSLOT];
    logic        m_repeat [NSLOT];
    logic [31:0] m_period [NSLOT];
    logic [63:0] m_deadline [NSLOT];
    logic        m_written [NSLOT];
    logic        m_wake_pending;
    logic [63:0] m_prev_time;
    logic [31:0] m_window;

    timer_word_t words_due[$];
    int errors = 0;
    int cycles = 0;
    bit hold_long = 0;

    initial begin
        in_ch.valid = 1'b0; in_ch.func = '0; in_ch.now_ms = '0; in_ch.slot_in = '0;
        in_ch.period_ms = '0; in_ch.repeat_req = 1'b0; in_ch.from_now = 1'b0;
        out_ch.ready = 1'b0;
    end

    // timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("deadline_timer_table_test NOT OK");
            $finish;
        end
    end

    function automatic bit any_on();
        for (int i = 0; i < NSLOT; i++) if (m_active[i]) return 1'b1;
        return 1'b0;
    endfunction

    // order by deadline, then by slot number
    function automatic bit earlier(int a, int b);
        if (m_deadline[a] != m_deadline[b]) return m_deadline[a] < m_deadline[b];
        return a < b;
    endfunction

    function automatic bit front_check(int s);
        for (int j = 0; j < NSLOT; j++)
            if (j != s && m_active[j] && earlier(j, s)) return 1'b0;
        if (m_wake_pending) return 1'b0;
        m_wake_pending = 1'b1;
        return 1'b1;
    endfunction

    // compute the words one command produces and update the table copy
    task automatic predict_word(input cmd_t c, output int nwords);
        timer_word_t r;
        timer_word_t batch[$];
        int f, e, cnt, m, s;
        bit due [NSLOT];
        bit roll;
        logic [63:0] start, win;
        r = '0;
        r.last = 1'b1;
        s = c.slot;
        case (c.func)
            F_ADD: begin
                f = -1;
                for (int i = 0; i < NSLOT; i++)
                    if (!m_active[i] && f < 0) f = i;
                if (f < 0) begin
                    r.status = ST_FULL;
                end else begin
                    m_active[f] = 1'b1;
                    m_repeat[f] = c.rep;
                    m_period[f] = c.period;
                    m_written[f] = 1'b1;
                    m_deadline[f] = c.now + 64'(c.period);
                    r.slot = f[3:0];
                    r.wake = front_check(f);
                end
            end
            F_CANCEL: begin
                if (m_active[s]) m_active[s] = 1'b0;
                else r.status = ST_INACT;
            end
            F_REFRESH: begin
                if (m_active[s]) m_deadline[s] = c.now + 64'(m_period[s]);
                else r.status = ST_INACT;
            end
            F_RESET: begin
                if (c.period == m_period[s] && !c.fnow) begin
                    // unchanged period: nothing to do
                end else if (!m_active[s]) begin
                    r.status = ST_INACT;
                end else begin
                    start = c.fnow ? c.now : m_deadline[s] - 64'(m_period[s]);
                    m_period[s] = c.period;
                    m_deadline[s] = start + 64'(c.period);
                    r.wake = front_check(s);
                end
            end
            F_NEXT: begin
                e = -1;
                r.wait_ms = ALL_ONES;
                m_wake_pending = 1'b0;
                for (int i = 0; i < NSLOT; i++)
                    if (m_active[i] && (e < 0 || earlier(i, e))) e = i;
                if (e >= 0)
                    r.wait_ms = (c.now >= m_deadline[e]) ? 64'd0 : m_deadline[e] - c.now;
            end
            F_EXPIRE: begin
                if (!any_on()) begin
                    r.status = ST_NONE;
                end else begin
                    win = 64'(m_window);
                    roll = (m_prev_time >= win) && (c.now < m_prev_time - win);
                    m_prev_time = c.now;
                    cnt = 0;
                    for (int i = 0; i < NSLOT; i++) begin
                        due[i] = m_active[i] && (roll || m_deadline[i] <= c.now);
                        if (due[i]) cnt++;
                    end
                    if (cnt == 0) r.status = ST_NONE;
                    for (int k = 0; k < cnt; k++) begin
                        m = -1;
                        for (int i = 0; i < NSLOT; i++)
                            if (due[i] && (m < 0 || earlier(i, m))) m = i;
                        due[m] = 1'b0;
                        if (m_repeat[m]) m_deadline[m] = c.now + 64'(m_period[m]);
                        else m_active[m] = 1'b0;
                        r = '0;
                        r.slot = m[3:0];
                        r.fired = 1'b1;
                        r.last = (k == cnt - 1);
                        batch.push_back(r);
                    end
                end
            end
            default: ;
        endcase
        if (batch.size() == 0) batch.push_back(r);
        foreach (batch[k]) begin
            batch[k].armed = any_on();
            words_due.push_back(batch[k]);
        end
        nwords = batch.size();
    endtask

    // sender: optional gap, then offer the word until taken
    task automatic send_word(input cmd_t c, input int gap);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.func <= c.func;
        in_ch.now_ms <= c.now;
        in_ch.slot_in <= c.slot;
        in_ch.period_ms <= c.period;
        in_ch.repeat_req <= c.rep;
        in_ch.from_now <= c.fnow;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    function automatic int draw_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 19);
    endfunction

    // receiver: random stall per word, one long hold on request
    initial begin
        int stall;
        timer_word_t x;
        timer_word_t got;
        @(posedge i_rst_n);
        forever begin
            stall = $urandom_range(0, 19);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (hold_long) begin
                stall = 600;
                hold_long = 0;
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end else if (!out_ch.ready) begin
                out_ch.ready <= 1'b1;
            end
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
            got = '{out_ch.status, out_ch.slot_out, out_ch.wait_ms, out_ch.fired,
                    out_ch.last, out_ch.front_wake, out_ch.any_armed};
            if (words_due.size() == 0) begin
                $error("unexpected result word");
                errors++;
            end else begin
                x = words_due.pop_front();
                if (got.status !== x.status) begin
                    $error("status exp %0d got %0d", x.status, got.status); errors++;
                end
                if (got.slot !== x.slot) begin
                    $error("slot_out exp %0d got %0d", x.slot, got.slot); errors++;
                end
                if (got.wait_ms !== x.wait_ms) begin
                    $error("wait_ms exp %0h got %0h", x.wait_ms, got.wait_ms); errors++;
                end
                if (got.fired !== x.fired) begin
                    $error("fired exp %0d got %0d", x.fired, got.fired); errors++;
                end
                if (got.last !== x.last) begin
                    $error("last exp %0d got %0d", x.last, got.last); errors++;
                end
                if (got.wake !== x.wake) begin
                    $error("front_wake exp %0d got %0d", x.wake, got.wake); errors++;
                end
                if (got.armed !== x.armed) begin
                    $error("any_armed exp %0d got %0d", x.armed, got.armed); errors++;
                end
            end
        end
    end

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (words_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // APB write of the window, then read it back
    task automatic set_window(input logic [31:0] v);
        drain();
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= 3'd0; pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        pwrite <= 1'b0; penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== v) begin
            $error("prdata exp %0h got %0h", v, prdata); errors++;
        end
        psel <= 1'b0; penable <= 1'b0;
        m_window = v;
        @(posedge i_clk);
    endtask

    function automatic cmd_t mk(logic [2:0] f, logic [63:0] t, logic [3:0] s,
                                logic [31:0] p, logic r, logic n);
        cmd_t c;
        c = '{f, t, s, p, r, n};
        return c;
    endfunction

    function automatic row_t row(cmd_t c, int cnt);
        return '{1'b0, c, cnt, 1'b0, 2'd0, 64'd0};
    endfunction

    function automatic row_t row_t_exp(cmd_t c, logic [1:0] st, logic [63:0] w);
        return '{1'b1 & 1'b0, c, 32'd1, 1'b1, st, w};
    endfunction

    function automatic row_t cfg_row(logic [31:0] v);
        return '{1'b1, mk(F_ADD, 64'd0, 4'd0, v, 1'b0, 1'b0), 32'd1, 1'b0, 2'd0, 64'd0};
    endfunction

    // random command with a moving clock
    logic [63:0] t_now;

    function automatic cmd_t rand_cmd();
        cmd_t c;
        int pick, sel;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
            0:       t_now = t_now - 64'($urandom_range(0, 8000000));
            1:       t_now = {$urandom, $urandom};
            2:       t_now = t_now + 64'($urandom_range(0, 4000000));
            default: t_now = t_now + 64'($urandom_range(0, 150));
        endcase
        c.now = t_now;
        c.slot = $urandom_range(0, NSLOT - 1);
        case ($urandom_range(0, 9))
            0:       c.period = 32'd0;
            1:       c.period = 32'hFFFF_FFFF;
            2, 3:    c.period = $urandom;
            default: c.period = $urandom_range(0, 300);
        endcase
        c.rep = $urandom_range(0, 1);
        c.fnow = $urandom_range(0, 1);
        if (pick < 30)      c.func = F_ADD;
        else if (pick < 40) c.func = F_CANCEL;
        else if (pick < 50) c.func = F_REFRESH;
        else if (pick < 65) c.func = F_RESET;
        else if (pick < 78) c.func = F_NEXT;
        else if (pick < 96) c.func = F_EXPIRE;
        else                c.func = (pick < 98) ? F_UNUSED6 : F_UNUSED7;
        // a reset may only address a slot whose period has been written
        if (c.func == F_RESET) begin
            if (!m_written[c.slot]) begin
                sel = -1;
                for (int i = 0; i < NSLOT; i++) if (m_written[i] && sel < 0) sel = i;
                if (sel < 0) c.func = F_NEXT;
                else c.slot = sel[3:0];
            end
            if ($urandom_range(0, 5) == 0) c.period = m_period[c.slot];
        end
        return c;
    endfunction

    // main sequence
    initial begin
        row_t rows[$];
        int n;
        logic [31:0] windows [4];
        for (int i = 0; i < NSLOT; i++) begin
            m_active[i] = 0; m_repeat[i] = 0; m_period[i] = 0;
            m_deadline[i] = 0; m_written[i] = 0;
        end
        m_wake_pending = 0;
        m_prev_time = 0;
        m_window = WINDOW_RESET;
        t_now = 64'd1000;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows.push_back(row_t_exp(mk(F_NEXT, 64'd0, 4'd0, 32'd0, 0, 0), ST_OK, ALL_ONES));
        rows.push_back(row_t_exp(mk(F_EXPIRE, 64'd5, 4'd0, 32'd0, 0, 0), ST_NONE, 64'd0));
        rows.push_back(row_t_exp(mk(F_CANCEL, 64'd5, 4'd3, 32'd0, 0, 0), ST_INACT, 64'd0));
        rows.push_back(row_t_exp(mk(F_REFRESH, 64'd5, 4'd15, 32'd0, 0, 0), ST_INACT, 64'd0));
        rows.push_back(row_t_exp(mk(F_UNUSED6, ALL_ONES, 4'd15, 32'hFFFF_FFFF, 1, 1),
                                 ST_OK, 64'd0));
        rows.push_back(row_t_exp(mk(F_UNUSED7, 64'd0, 4'd0, 32'd0, 0, 0), ST_OK, 64'd0));
        rows.push_back(row(mk(F_ADD, 64'd100, 4'd0, 32'd0, 0, 0), 1));
        // deadline wraps past all ones
        rows.push_back(row(mk(F_ADD, ALL_ONES, 4'd0, 32'hFFFF_FFFF, 1, 0), 1));
        rows.push_back(row(mk(F_ADD, 64'd200, 4'd0, 32'd50, 1, 0), 14));
        rows.push_back(row_t_exp(mk(F_ADD, 64'd200, 4'd0, 32'd7, 0, 0), ST_FULL, 64'd0));
        rows.push_back(row(mk(F_NEXT, 64'd200, 4'd0, 32'd0, 0, 0), 1));
        rows.push_back(row(mk(F_RESET, 64'd210, 4'd2, 32'd50, 0, 0), 1));
        rows.push_back(row(mk(F_RESET, 64'd210, 4'd2, 32'd10, 0, 0), 1));
        rows.push_back(row(mk(F_RESET, 64'd220, 4'd3, 32'd5, 0, 1), 1));
        rows.push_back(row(mk(F_REFRESH, 64'd300, 4'd4, 32'd0, 0, 0), 1));
        rows.push_back(row(mk(F_CANCEL, 64'd300, 4'd5, 32'd0, 0, 0), 1));
        rows.push_back(row(mk(F_EXPIRE, 64'd250, 4'd0, 32'd0, 0, 0), 1));
        rows.push_back(row(mk(F_EXPIRE, 64'd0, 4'd0, 32'd0, 0, 0), 1));
        rows.push_back(cfg_row(32'd1));
        rows.push_back(row(mk(F_EXPIRE, 64'd1000, 4'd0, 32'd0, 0, 0), 1));
        // clock jumps back past the window: everything is due
        rows.push_back(row(mk(F_EXPIRE, 64'd10, 4'd0, 32'd0, 0, 0), 1));
        rows.push_back(row(mk(F_NEXT, ALL_ONES, 4'd0, 32'd0, 0, 0), 1));
        rows.push_back(cfg_row(32'hFFFF_FFFF));
        rows.push_back(row(mk(F_EXPIRE, ALL_ONES, 4'd0, 32'd0, 0, 0), 1));

        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                set_window(rows[i].cmd.period);
            end else begin
                for (int k = 0; k < rows[i].count; k++) begin
                    predict_word(rows[i].cmd, n);
                    if (rows[i].typed) begin
                        words_due[words_due.size() - 1].status = rows[i].t_status;
                        words_due[words_due.size() - 1].wait_ms = rows[i].t_wait;
                    end
                    send_word(rows[i].cmd, draw_gap());
                end
            end
        end

        // random phases under different windows
        windows[0] = WINDOW_RESET;
        windows[1] = 32'd1;
        windows[2] = 32'hFFFF_FFFF;
        windows[3] = $urandom_range(1, 20000);
        for (int ph = 0; ph < 4; ph++) begin
            set_window(windows[ph]);
            for (int k = 0; k < 70; k++) begin
                cmd_t c;
                if (ph == 1 && k == 10) hold_long = 1;
                // pause until everything is out
                if (ph == 2 && k == 35) drain();
                c = rand_cmd();
                predict_word(c, n);
                send_word(c, (ph == 1 && k >= 10 && k < 20) ? 0 : draw_gap());
            end
        end

        in_ch.valid <= 1'b0;
        while (words_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0) begin
            $display("deadline_timer_table_test OK");
        end else begin
            $display("deadline_timer_table_test NOT OK");
        end
        $finish;
    end
endmodule
